// ===== hdl/cdpg_pkg.sv =====
package cdpg_pkg;

   // default duty width, overridable on the top level
   localparam int DUTY_BITS_DEF = 10;

   localparam int ANGLE_W    = 17;                  // signed angle, 1/256 degree
   localparam int SQ_W       = 2 * ANGLE_W;         // roll^2 + pitch^2 fits here
   localparam int TILT_W     = ANGLE_W;             // floor square root of SQ_W bits
   localparam int REM_W      = TILT_W + 2;          // partial remainder of the root
   localparam int GAIN_W     = 16;
   localparam int PROD_W     = TILT_W + GAIN_W;
   localparam int FRAC_SHIFT = 16;
   localparam int TIME_W     = 32;
   localparam int MAXD_W     = 10;

   localparam int ROOT_STEPS = SQ_W / 2;            // one result bit per step
   localparam int STEP_W     = $clog2(ROOT_STEPS);

   localparam int REQ_DATA_W = 72;                  // 67 field bits padded to bytes
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_DEAD_ZONE = 2'd0,
      CSR_GAIN_Q8   = 2'd1,
      CSR_MAX_DUTY  = 2'd2,
      CSR_MAX_PULSE = 2'd3
   } csr_idx_type;

   localparam logic [15:0]       DEAD_ZONE_RST = 16'd512;
   localparam logic [15:0]       GAIN_Q8_RST   = 16'd256;
   localparam logic [MAXD_W-1:0] MAX_DUTY_RST  = 10'd1023;
   localparam logic [15:0]       MAX_PULSE_RST = 16'd500;

   typedef enum logic [2:0] {
      STS_IDLE        = 3'd0,
      STS_DRIVING     = 3'd1,
      STS_FUSE_OPEN   = 3'd2,
      STS_INTERLOCK   = 3'd3,
      STS_FUSE_TRIP   = 3'd4,
      STS_RESET_DONE  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_ROLL,
      ST_SQ_PITCH,
      ST_ROOT,
      ST_DIFF,
      ST_SCALE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic [15:0]       dead_zone;
      logic [GAIN_W-1:0] gain_q8;
      logic [MAXD_W-1:0] max_duty;
      logic [15:0]       max_pulse_ms;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic sq_roll;
      logic sq_pitch;
      logic root_step;
      logic diff;
      logic scale;
      logic commit;
   } cmd_type;

endpackage

// ===== hdl/cdpg_ctrl.sv =====
module cdpg_ctrl import cdpg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  logic    in_mode,
   input  logic    out_free,
   output logic    in_ready,
   output cmd_type cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      in_ready = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               // fuse reset words skip the arithmetic
               state_in = in_mode ? ST_COMMIT : ST_SQ_ROLL;
            end
         end
         ST_SQ_ROLL: begin
            cmd.sq_roll = 1'b1;
            state_in    = ST_SQ_PITCH;
         end
         ST_SQ_PITCH: begin
            cmd.sq_pitch = 1'b1;
            state_in     = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_root_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT) |-> (step_ff <= STEP_W'(ROOT_STEPS - 1)))
      else $error("root step counter overran");

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_commit_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE))
      else $error("controller did not return to idle after commit");

endmodule

// ===== hdl/cdpg_dp.sv =====
module cdpg_dp import cdpg_pkg::*; #(
   parameter int DUTY_BITS = DUTY_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  cfg_type                    cfg,
   input  logic                       in_mode,
   input  logic signed [ANGLE_W-1:0]  in_roll,
   input  logic signed [ANGLE_W-1:0]  in_pitch,
   input  logic [TIME_W-1:0]          in_now,
   input  logic                       in_iso,
   output logic [DUTY_BITS-1:0]       res_duty,
   output logic                       res_fuse,
   output status_type                 res_status
);

   localparam logic [TILT_W-1:0] DUTY_LIM = TILT_W'((1 << DUTY_BITS) - 1);

   // latched word
   logic                  mode_ff, iso_ff;
   logic [TIME_W-1:0]     now_ff;
   logic [ANGLE_W-1:0]    roll_abs_ff, pitch_abs_ff;
   // arithmetic
   logic [SQ_W-1:0]       sum_ff, sum_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [TILT_W-1:0]     root_ff, root_in;
   logic                  below_ff;
   logic [TILT_W-1:0]     diff_ff;
   logic [PROD_W-1:0]     prod_ff;
   // block state
   logic                  fuse_ff, fuse_in;
   logic [DUTY_BITS-1:0]  applied_ff, applied_in;
   logic [TIME_W-1:0]     start_ff, start_in;

   logic [ANGLE_W-1:0]    roll_abs, pitch_abs, mul_op;
   logic [SQ_W-1:0]       sq;
   logic [REM_W+1:0]      cand, trial;
   logic [TILT_W-1:0]     raw, cap, clamped;
   logic [DUTY_BITS-1:0]  req;
   logic [TIME_W-1:0]     elapsed;
   status_type            status;

   assign roll_abs  = in_roll[ANGLE_W-1]  ? ANGLE_W'(-in_roll)  : ANGLE_W'(in_roll);
   assign pitch_abs = in_pitch[ANGLE_W-1] ? ANGLE_W'(-in_pitch) : ANGLE_W'(in_pitch);

   // one shared squarer, used twice
   assign mul_op = cmd.sq_pitch ? pitch_abs_ff : roll_abs_ff;
   assign sq     = SQ_W'(mul_op) * SQ_W'(mul_op);

   // restoring root: bring down two radicand bits, try (root << 2) | 1
   assign cand  = {rem_ff, sum_ff[SQ_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_comb begin
      sum_in  = sum_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (cmd.sq_roll) begin
         sum_in  = sq;
         rem_in  = '0;
         root_in = '0;
      end else if (cmd.sq_pitch) begin
         sum_in = sum_ff + sq;
      end else if (cmd.root_step) begin
         sum_in = {sum_ff[SQ_W-3:0], 2'b00};
         if (cand >= trial) begin
            rem_in  = REM_W'(cand - trial);
            root_in = {root_ff[TILT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(cand);
            root_in = {root_ff[TILT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff      <= in_mode;
         iso_ff       <= in_iso;
         now_ff       <= in_now;
         roll_abs_ff  <= roll_abs;
         pitch_abs_ff <= pitch_abs;
      end
      sum_ff  <= sum_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (cmd.diff) begin
         below_ff <= root_ff < TILT_W'(cfg.dead_zone);
         diff_ff  <= root_ff - TILT_W'(cfg.dead_zone);
      end
      if (cmd.scale) begin
         prod_ff <= PROD_W'(diff_ff) * PROD_W'(cfg.gain_q8);
      end
   end

   // clamp to the smaller of max_duty and the port range
   assign raw     = prod_ff[PROD_W-1:FRAC_SHIFT];
   assign cap     = (TILT_W'(cfg.max_duty) > DUTY_LIM) ? DUTY_LIM : TILT_W'(cfg.max_duty);
   assign clamped = (raw > cap) ? cap : raw;
   assign req     = below_ff ? '0 : DUTY_BITS'(clamped);
   assign elapsed = now_ff - start_ff;

   always_comb begin
      fuse_in    = fuse_ff;
      applied_in = applied_ff;
      start_in   = start_ff;
      status     = STS_IDLE;
      if (mode_ff) begin
         fuse_in    = 1'b0;
         applied_in = '0;
         start_in   = '0;
         status     = STS_RESET_DONE;
      end else if (fuse_ff) begin
         applied_in = '0;
         status     = STS_FUSE_OPEN;
      end else if ((req != '0) && !iso_ff) begin
         applied_in = '0;
         status     = STS_INTERLOCK;
      end else if ((req != '0) && (applied_ff != '0) &&
                   (elapsed > TIME_W'(cfg.max_pulse_ms))) begin
         fuse_in    = 1'b1;
         applied_in = '0;
         status     = STS_FUSE_TRIP;
      end else begin
         applied_in = req;
         if (req != '0) begin
            if (applied_ff == '0) begin
               start_in = now_ff;
            end
            status = STS_DRIVING;
         end else begin
            start_in = '0;
            status   = STS_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fuse_ff    <= 1'b0;
         applied_ff <= '0;
         start_ff   <= '0;
      end else if (cmd.commit) begin
         fuse_ff    <= fuse_in;
         applied_ff <= applied_in;
         start_ff   <= start_in;
      end
   end

   assign res_duty   = applied_in;
   assign res_fuse   = fuse_in;
   assign res_status = status;

   a_fuse_zero_duty: assert property (@(posedge clock) disable iff (reset)
      (applied_ff != '0) |-> !fuse_ff)
      else $error("nonzero duty held while fuse is open");

   a_trip_sets_fuse: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (status == STS_FUSE_TRIP)) |=> fuse_ff)
      else $error("fuse trip not recorded");

endmodule

// ===== hdl/coil_drive_pulse_guard.sv =====
// Coil drive pulse guard.
// req_ channel: one word per attitude sample or fuse reset. req_tuser is the
//   mode (0 update, 1 clear the fuse); req_tdata carries roll, pitch, time and
//   the relay-isolated flag. rsp_ channel: exactly one word per request with
//   the applied duty, the fuse state and a status code.
// Processing: an update word is accepted in idle, squared (roll, then pitch,
//   on one 17x17 multiplier), rooted by a restoring square root at one bit
//   per cycle, offset by the dead zone and scaled by gain, then committed
//   to the result register. No new word is taken until the last one is
//   committed; the next can be taken in the cycle after the commit. Fuse
//   reset words skip the arithmetic and go from idle straight to commit.
// The result sits in an output register; while it waits the block already
//   takes and works the next word, and only the commit step stalls until the
//   register is free. A stalled receiver therefore never loses or repeats a word.
// Reset (synchronous, active high) clears the fuse, the applied duty, the
//   pulse start time, the controller and the output valid, and loads the
//   register defaults. The user must write registers through the csr_ port
//   only while no word is in flight; the block itself does not enforce this.
module coil_drive_pulse_guard import cdpg_pkg::*; #(
   parameter int DUTY_BITS = DUTY_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // stream in
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [16:0] roll_angle, [33:17] pitch_angle, [65:34] now_ms, [66] relay_isolated
   input  logic [REQ_DATA_W-1:0]                 req_tdata,
   // [0] mode
   input  logic                                  req_tuser,
   // stream out
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [DUTY_BITS-1:0] duty, then fuse_open, then status (3 bits)
   output logic [((DUTY_BITS + 4 + 7) / 8) * 8 - 1:0] rsp_tdata,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]                 csr_paddr,
   input  logic [CSR_DATA_W-1:0]                 csr_pwdata,
   output logic [CSR_DATA_W-1:0]                 csr_prdata,
   output logic                                  csr_pready
);

   localparam int RSP_W = ((DUTY_BITS + 4 + 7) / 8) * 8;

   cfg_type               cfg_ff, cfg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   cmd_type               cmd;
   logic                  out_free;
   logic [DUTY_BITS-1:0]  res_duty;
   logic                  res_fuse;
   status_type            res_status;
   csr_idx_type           csr_idx;
   logic                  csr_wr;

   // register file
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_DEAD_ZONE: cfg_in.dead_zone    = csr_pwdata[15:0];
            CSR_GAIN_Q8:   cfg_in.gain_q8      = csr_pwdata[GAIN_W-1:0];
            CSR_MAX_DUTY:  cfg_in.max_duty     = csr_pwdata[MAXD_W-1:0];
            CSR_MAX_PULSE: cfg_in.max_pulse_ms = csr_pwdata[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_DEAD_ZONE: csr_prdata = CSR_DATA_W'(cfg_ff.dead_zone);
         CSR_GAIN_Q8:   csr_prdata = CSR_DATA_W'(cfg_ff.gain_q8);
         CSR_MAX_DUTY:  csr_prdata = CSR_DATA_W'(cfg_ff.max_duty);
         CSR_MAX_PULSE: csr_prdata = CSR_DATA_W'(cfg_ff.max_pulse_ms);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone    <= DEAD_ZONE_RST;
         cfg_ff.gain_q8      <= GAIN_Q8_RST;
         cfg_ff.max_duty     <= MAX_DUTY_RST;
         cfg_ff.max_pulse_ms <= MAX_PULSE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer
   cdpg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_mode  (req_tuser),
      .out_free (out_free),
      .in_ready (req_tready),
      .cmd      (cmd)
   );

   // arithmetic and guard state
   cdpg_dp #(
      .DUTY_BITS (DUTY_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .in_mode    (req_tuser),
      .in_roll    (req_tdata[16:0]),
      .in_pitch   (req_tdata[33:17]),
      .in_now     (req_tdata[65:34]),
      .in_iso     (req_tdata[66]),
      .res_duty   (res_duty),
      .res_fuse   (res_fuse),
      .res_status (res_status)
   );

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({res_status, res_fuse, res_duty});
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result committed over an undelivered word");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.root_step |-> !req_tready)
      else $error("input ready while a word is being worked");

endmodule
